[rtl/mclp_pkg.sv]
// Shared types and constants for the motion command line parser.
// No dependencies; imported by every module of the block.
package mclp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SPEED_W = 16;
    localparam int unsigned DIR_W   = 3;

    // ASCII codes recognized by the parser
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_F     = 8'h46;
    localparam logic [BYTE_W-1:0] CH_B     = 8'h42;
    localparam logic [BYTE_W-1:0] CH_L     = 8'h4C;
    localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
    localparam logic [BYTE_W-1:0] CH_S     = 8'h53;

    // Direction codes as reported on the result channel
    localparam logic [DIR_W-1:0] DIR_F = 3'd0;
    localparam logic [DIR_W-1:0] DIR_B = 3'd1;
    localparam logic [DIR_W-1:0] DIR_L = 3'd2;
    localparam logic [DIR_W-1:0] DIR_R = 3'd3;
    localparam logic [DIR_W-1:0] DIR_S = 3'd4;

    localparam logic [SPEED_W-1:0] SPEED_MAX_RESET = 16'd1000;

    typedef struct packed {
        logic               valid;
        logic               is_error;
        logic [DIR_W-1:0]   direction;
        logic [SPEED_W-1:0] speed;
        logic               led_select;
    } parse_result_t;

endpackage

[rtl/mclp_in_reg.sv]
// Input register of the motion command line parser: holds one received byte.
// Depends on mclp_pkg.
module mclp_in_reg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [mclp_pkg::BYTE_W-1:0] s_rx_byte,
    input  logic                        advance,
    output logic                        byte_valid,
    output logic [mclp_pkg::BYTE_W-1:0] byte_data
);
    import mclp_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    // take a new byte when empty or when the held one moves on this cycle
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

[rtl/mclp_parser.sv]
// Line parser state machine: updates the line state for one byte per step
// and forms the result for that byte. Depends on mclp_pkg.
module mclp_parser #(
    parameter int LINE_BUF_SIZE = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic [mclp_pkg::BYTE_W-1:0]  byte_data,
    input  logic [mclp_pkg::SPEED_W-1:0] speed_max,
    output mclp_pkg::parse_result_t      result
);
    import mclp_pkg::*;

    localparam int unsigned LEN_W = $clog2(LINE_BUF_SIZE);
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_BUF_SIZE - 1);
    localparam int unsigned ACC_W = SPEED_W + 4;

    typedef enum logic [2:0] {
        PH_DIR,
        PH_COMMA,
        PH_FIRST,
        PH_DIGITS,
        PH_BAD,
        PH_DONE
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [DIR_W-1:0]   dir_reg, dir_next;
    logic [SPEED_W-1:0] accum_reg, accum_next;

    logic               is_lf, is_cr, line_full, line_ok, err;
    logic [ACC_W-1:0]   acc_wide, acc_cand;
    logic               is_digit;

    assign is_lf     = (byte_data == CH_LF);
    assign is_cr     = (byte_data == CH_CR);
    assign line_full = (len_reg == LEN_LAST);
    assign line_ok   = (phase_reg == PH_DIGITS) || (phase_reg == PH_DONE);
    assign is_digit  = (byte_data >= CH_ZERO) && (byte_data <= CH_NINE);

    // accum * 10 + digit
    assign acc_wide = ACC_W'(accum_reg);
    assign acc_cand = (acc_wide << 3) + (acc_wide << 1) + ACC_W'(byte_data[3:0]);

    always_comb begin
        phase_next = phase_reg;
        len_next   = len_reg;
        dir_next   = dir_reg;
        accum_next = accum_reg;
        if (step) begin
            if (is_lf || (!is_cr && line_full)) begin
                // end of line or overflow: start a fresh line
                phase_next = PH_DIR;
                len_next   = '0;
                dir_next   = DIR_F;
                accum_next = '0;
            end else if (!is_cr) begin
                len_next = len_reg + LEN_W'(1);
                if (phase_reg != PH_BAD && phase_reg != PH_DONE) begin
                    if (byte_data == CH_NUL) begin
                        phase_next = (phase_reg == PH_DIGITS) ? PH_DONE : PH_BAD;
                    end else begin
                        unique case (phase_reg)
                            PH_DIR: begin
                                phase_next = PH_COMMA;
                                case (byte_data)
                                    CH_F:    dir_next = DIR_F;
                                    CH_B:    dir_next = DIR_B;
                                    CH_L:    dir_next = DIR_L;
                                    CH_R:    dir_next = DIR_R;
                                    CH_S:    dir_next = DIR_S;
                                    default: phase_next = PH_BAD;
                                endcase
                            end
                            PH_COMMA: begin
                                phase_next = (byte_data == CH_COMMA) ? PH_FIRST : PH_BAD;
                            end
                            PH_FIRST, PH_DIGITS: begin
                                if (!is_digit || (acc_cand > ACC_W'(speed_max))) begin
                                    phase_next = PH_BAD;
                                end else begin
                                    accum_next = acc_cand[SPEED_W-1:0];
                                    phase_next = PH_DIGITS;
                                end
                            end
                            default: phase_next = phase_reg;
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DIR;
            len_reg   <= '0;
            dir_reg   <= DIR_F;
            accum_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            dir_reg   <= dir_next;
            accum_reg <= accum_next;
        end
    end

    // result for the byte currently presented
    assign err = is_lf ? !line_ok : 1'b1;

    always_comb begin
        result.valid      = (is_lf && (len_reg != '0)) || (!is_lf && !is_cr && line_full);
        result.is_error   = err;
        result.direction  = err ? DIR_F : dir_reg;
        result.speed      = err ? '0 : accum_reg;
        result.led_select = !err && (dir_reg >= DIR_L);
    end

endmodule

[rtl/motion_command_line_parser.sv]
// Top level of the motion command line parser: input register, parser and
// result register. Depends on mclp_pkg, mclp_in_reg and mclp_parser.
//
// Parses serial text lines "<F|B|L|R|S>,<digits>" one byte per transaction and
// reports, for each non-empty line, an acknowledge (direction, speed, LED
// select) or an error when its line feed arrives; a byte that would overflow a
// line of LINE_BUF_SIZE-1 bytes gives an error at once. One byte is accepted
// every cycle unless a byte stalls; each result is registered after the input
// register. The input and the one-entry result register keep bytes flowing
// while a result waits; only a byte that produces a result stalls behind an
// untaken result. The user must write speed_max through the cfg_ channel
// (always ready) only while the block is idle, unenforced; it resets to 1000.
module motion_command_line_parser #(
    parameter int LINE_BUF_SIZE = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [mclp_pkg::BYTE_W-1:0]  s_rx_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_is_error,
    output logic [mclp_pkg::DIR_W-1:0]   m_direction,
    output logic [mclp_pkg::SPEED_W-1:0] m_speed,
    output logic                         m_led_select,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mclp_pkg::SPEED_W-1:0] cfg_speed_max
);
    import mclp_pkg::*;

    logic               byte_valid;
    logic [BYTE_W-1:0]  byte_data;
    logic               advance;
    logic               out_load;
    parse_result_t      result;

    logic [SPEED_W-1:0] speed_max_reg;
    logic               out_valid_reg, out_valid_next;
    logic               is_error_reg;
    logic [DIR_W-1:0]   direction_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic               led_select_reg;

    mclp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    mclp_parser #(
        .LINE_BUF_SIZE (LINE_BUF_SIZE)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .byte_data (byte_data),
        .speed_max (speed_max_reg),
        .result    (result)
    );

    // hold a result-producing byte while the result register is still full
    assign advance  = byte_valid && (!result.valid || !out_valid_reg || m_ready);
    assign out_load = advance && result.valid;

    assign cfg_ready = 1'b1;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            speed_max_reg <= SPEED_MAX_RESET;
        end else begin
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                speed_max_reg <= cfg_speed_max;
            end
        end
        if (out_load) begin
            is_error_reg   <= result.is_error;
            direction_reg  <= result.direction;
            speed_reg      <= result.speed;
            led_select_reg <= result.led_select;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_is_error   = is_error_reg;
    assign m_direction  = direction_reg;
    assign m_speed      = speed_reg;
    assign m_led_select = led_select_reg;

endmodule
